// File: rtl/joint_histogram_binner_core_assert.svh
// Assertion macros shared by the histogram binner modules.
`ifndef JOINT_HISTOGRAM_BINNER_CORE_ASSERT_SVH
`define JOINT_HISTOGRAM_BINNER_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define JHB_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("histogram binner check failed");

// Check that a condition implies a consequence in the next cycle.
`define JHB_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("histogram binner check failed");

`endif

// File: rtl/jhb_pkg.sv
// Shared types, constants and codes of the joint histogram binner.
`default_nettype none

package jhb_pkg;

  localparam int BINS_DEFAULT = 21;
  localparam int VAL_W        = 16;
  localparam int WID_W        = 15;
  localparam int CNT_W        = 32;
  localparam int IDX_W        = 5;
  localparam int STS_W        = 2;

  localparam logic signed [VAL_W-1:0] LOW_EDGE_RESET  = -16'sd1000;
  localparam logic        [WID_W-1:0] BIN_WIDTH_RESET = 15'd100;

  // Operation codes of an input item
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes on the configuration channel
  localparam logic REG_LOW_EDGE  = 1'b0;
  localparam logic REG_BIN_WIDTH = 1'b1;

  // Result status codes
  localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STATUS_ROW   = 2'd2;

  // Request to the binning unit
  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] value;
  } bin_req_t;

  // Answer of the binning unit
  typedef struct packed {
    logic             done;
    logic             out_of_range;
    logic [IDX_W-1:0] index;
  } bin_res_t;

endpackage

`default_nettype wire

// File: rtl/jhb_count_ram.sv
// Counter store: one write port and one registered read port.
`default_nettype none

module jhb_count_ram #(
  parameter int DEPTH = jhb_pkg::BINS_DEFAULT * jhb_pkg::BINS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [jhb_pkg::CNT_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [jhb_pkg::CNT_W-1:0] rd_data
);

  logic [jhb_pkg::CNT_W-1:0] mem [DEPTH];

  // Write one counter
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/jhb_bin_unit.sv
// Binning unit: iterative shift-subtract divider that maps a score to a bin.
`default_nettype none
`include "joint_histogram_binner_core_assert.svh"

module jhb_bin_unit #(
  parameter int BINS = jhb_pkg::BINS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  jhb_pkg::bin_req_t               req,
  input  logic signed [jhb_pkg::VAL_W-1:0] low_edge,
  input  logic        [jhb_pkg::WID_W-1:0] bin_width,
  output jhb_pkg::bin_res_t               res
);

  localparam int IW = $clog2(BINS);
  localparam int KW = $clog2(IW + 1);
  localparam int CW = jhb_pkg::VAL_W + IW;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                   state;
  logic [jhb_pkg::VAL_W-1:0] rem;
  logic [IW-1:0]             quo;
  logic [KW-1:0]             k;

  logic signed [jhb_pkg::VAL_W:0] diff;
  logic [CW-1:0]                  shifted;
  logic                           ge;
  logic [IW-1:0]                  quo_next;
  logic                           in_range;

  // Offset from the lower edge, and the shared compare of one step
  assign diff     = {req.value[jhb_pkg::VAL_W-1], req.value}
                  - {low_edge[jhb_pkg::VAL_W-1], low_edge};
  assign shifted  = CW'(bin_width) << k;
  assign ge       = CW'(rem) >= shifted;
  assign quo_next = ge ? (quo | (IW'(1) << k)) : quo;
  assign in_range = {1'b0, quo_next} < (IW + 1)'(BINS);

  // Sequence the steps: overflow check first, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            if (diff[jhb_pkg::VAL_W] || (bin_width == '0)) begin
              res.done         <= 1'b1;
              res.out_of_range <= 1'b1;
              res.index        <= '0;
            end else begin
              rem   <= diff[jhb_pkg::VAL_W-1:0];
              quo   <= '0;
              k     <= KW'(IW);
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (k == KW'(IW)) begin
            if (ge) begin
              res.done         <= 1'b1;
              res.out_of_range <= 1'b1;
              res.index        <= '0;
              state            <= D_IDLE;
            end else begin
              k <= k - KW'(1);
            end
          end else begin
            if (ge) begin
              rem <= rem - shifted[jhb_pkg::VAL_W-1:0];
            end
            quo <= quo_next;
            if (k == '0) begin
              res.done         <= 1'b1;
              res.out_of_range <= !in_range;
              res.index        <= jhb_pkg::IDX_W'(quo_next);
              state            <= D_IDLE;
            end else begin
              k <= k - KW'(1);
            end
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  `JHB_ASSERT_SAME(a_start_when_idle, req.start, state == D_IDLE)
  `JHB_ASSERT_SAME(a_step_bounded, state == D_RUN, k <= KW'(IW))
  `JHB_ASSERT_SAME(a_index_in_bins, res.done && !res.out_of_range,
                   (jhb_pkg::IDX_W + 1)'(res.index) < (jhb_pkg::IDX_W + 1)'(BINS))

endmodule

`default_nettype wire

// File: rtl/joint_histogram_binner_core.sv
// Top level of the joint histogram binner: sequencer, registers and result port.
`default_nettype none
`include "joint_histogram_binner_core_assert.svh"

// Joint 2-D histogram of score pairs with BINS x BINS saturating counters.
// Commands: raise start with the payload while busy is low; the item is
// taken at that edge. opcode accumulate bins both scores and increments the
// counter; opcode read streams one row of counts.
// Results: each appears for one cycle with result_strobe high; the receiver
// cannot stall, so nothing is held back. last marks the final result.
// Flow with W = clog2(BINS) quotient bits: each score goes through the
// shared shift-subtract divider in turn, then the counter is read from the
// read port and written back through the write port of the store; the
// second score is not divided when the first is out of range. A row read
// streams one count a cycle from the read port. An invalid row answers in
// the cycle after start.
// Configuration: cfg_valid/cfg_ready write low_edge (index 0) or bin_width
// (index 1); cfg_ready is always high. Write only while idle.
// Reset: registers take their defaults and a clearing pass zeroes the
// BINS * BINS counters of the store, one counter a cycle, busy high
// meanwhile.
module joint_histogram_binner_core #(
  parameter int BINS = jhb_pkg::BINS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic signed [jhb_pkg::VAL_W-1:0] first_value,
  input  logic signed [jhb_pkg::VAL_W-1:0] second_value,
  input  logic        [jhb_pkg::IDX_W-1:0] row_select,
  output logic                             result_strobe,
  output logic        [jhb_pkg::CNT_W-1:0] count,
  output logic        [jhb_pkg::IDX_W-1:0] column,
  output logic        [jhb_pkg::IDX_W-1:0] row,
  output logic        [jhb_pkg::STS_W-1:0] status,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic        [jhb_pkg::VAL_W-1:0] cfg_data
);

  localparam int IW    = $clog2(BINS);
  localparam int DEPTH = BINS * BINS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_RD, S_WR, S_ROWA, S_ROW
  } state_t;

  state_t                           state;
  logic [AW-1:0]                    addr;
  logic [IW-1:0]                    col_q;
  logic [IW-1:0]                    row_q;
  logic signed [jhb_pkg::VAL_W-1:0] second_q;
  logic signed [jhb_pkg::VAL_W-1:0] low_edge;
  logic        [jhb_pkg::WID_W-1:0] bin_width;

  jhb_pkg::bin_req_t          req;
  jhb_pkg::bin_res_t          res;
  logic                       accept;
  logic                       row_bad;
  logic                       last_col;
  logic                       wr_en;
  logic [jhb_pkg::CNT_W-1:0]  wr_data;
  logic                       rd_en;
  logic [jhb_pkg::CNT_W-1:0]  rd_data;
  logic [jhb_pkg::CNT_W-1:0]  inc;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign row_bad   = {1'b0, row_select} >= (jhb_pkg::IDX_W + 1)'(BINS);
  assign last_col  = (col_q == IW'(BINS - 1));
  assign inc       = (rd_data == '1) ? rd_data : rd_data + 1'b1;

  // Start the divider on the first score at transfer, the second after it
  always_comb begin
    req.start = 1'b0;
    req.value = second_q;
    if (state == S_IDLE) begin
      req.start = accept && (opcode == jhb_pkg::OP_ACCUM);
      req.value = first_value;
    end else if (state == S_DIV1) begin
      req.start = res.done && !res.out_of_range;
    end
  end

  // Drive the counter store ports
  assign wr_en   = (state == S_CLEAR) || (state == S_WR);
  assign wr_data = (state == S_WR) ? inc : '0;
  assign rd_en   = (state == S_RD) || (state == S_ROWA) || ((state == S_ROW) && !last_col);

  jhb_bin_unit #(.BINS(BINS)) u_bin (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .low_edge  (low_edge),
    .bin_width (bin_width),
    .res       (res)
  );

  jhb_count_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_edge  <= jhb_pkg::LOW_EDGE_RESET;
      bin_width <= jhb_pkg::BIN_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jhb_pkg::REG_LOW_EDGE:  low_edge  <= cfg_data;
        jhb_pkg::REG_BIN_WIDTH: bin_width <= cfg_data[jhb_pkg::WID_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence each command and register its results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      addr          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            second_q <= second_value;
            if (opcode == jhb_pkg::OP_ACCUM) begin
              state <= S_DIV1;
            end else if (row_bad) begin
              result_strobe <= 1'b1;
              count         <= '0;
              column        <= '0;
              row           <= row_select;
              status        <= jhb_pkg::STATUS_ROW;
              last          <= 1'b1;
            end else begin
              row_q <= row_select[IW-1:0];
              addr  <= AW'(row_select[IW-1:0]) * AW'(BINS);
              state <= S_ROWA;
            end
          end
        end
        S_DIV1, S_DIV2: begin
          if (res.done) begin
            if (res.out_of_range) begin
              result_strobe <= 1'b1;
              count         <= '0;
              column        <= '0;
              row           <= '0;
              status        <= jhb_pkg::STATUS_RANGE;
              last          <= 1'b1;
              state         <= S_IDLE;
            end else if (state == S_DIV1) begin
              col_q <= res.index[IW-1:0];
              state <= S_DIV2;
            end else begin
              row_q <= res.index[IW-1:0];
              addr  <= AW'(res.index[IW-1:0]) * AW'(BINS) + AW'(col_q);
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          result_strobe <= 1'b1;
          count         <= inc;
          column        <= jhb_pkg::IDX_W'(col_q);
          row           <= jhb_pkg::IDX_W'(row_q);
          status        <= jhb_pkg::STATUS_OK;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        S_ROWA: begin
          addr  <= addr + 1'b1;
          col_q <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          result_strobe <= 1'b1;
          count         <= rd_data;
          column        <= jhb_pkg::IDX_W'(col_q);
          row           <= jhb_pkg::IDX_W'(row_q);
          status        <= jhb_pkg::STATUS_OK;
          last          <= last_col;
          if (last_col) begin
            state <= S_IDLE;
          end else begin
            addr  <= addr + 1'b1;
            col_q <= col_q + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `JHB_ASSERT_SAME(a_error_is_last, result_strobe && (status != jhb_pkg::STATUS_OK), last)
  `JHB_ASSERT_NEXT(a_row_contiguous, result_strobe && !last, result_strobe)
  `JHB_ASSERT_SAME(a_quiet_in_clear, state == S_CLEAR, !result_strobe)

endmodule

`default_nettype wire
